// ===== hw/rtl/mep_pkg.sv =====
package mep_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_X_MIN = 3'd0;
	localparam logic [2:0] REG_X_MAX = 3'd1;
	localparam logic [2:0] REG_Y_MIN = 3'd2;
	localparam logic [2:0] REG_Y_MAX = 3'd3;
	localparam logic [2:0] REG_WIDTH = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;
	localparam logic [2:0] REG_LIMIT = 3'd6;

	// Fixed field widths
	localparam int COORD_W = 32;
	localparam int DIM_W = 13;
	localparam int PIX_W = 12;
	localparam int COUNT_W = 16;
	localparam int COLOUR_W = 24;

	// Colour scale and escape radius squared
	localparam logic [COLOUR_W-1:0] COLOUR_SCALE = 24'hFF3FFF;
	localparam int ESCAPE_RADIUS_SQ = 4;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP_MUL,
		ST_DIV_LD,
		ST_DIV,
		ST_MAP_ADD,
		ST_IT_XX,
		ST_IT_YY,
		ST_IT_XY,
		ST_IT_UPD,
		ST_CL_MUL,
		ST_DONE
	} mep_state_t;

endpackage

// ===== hw/rtl/mandelbrot_escape_pixel_top.sv =====
// Channel   Ports                                   Handshake
// pixel     start, pixel_col, pixel_row             taken when start && !busy
// result    done, escape_count, pixel_colour        valid while done, one cycle
// config    wr_en, wr_index, wr_data                written when wr_en
//
// One shared 33x33 multiplier and one radix-2 divider (45 steps) do all the work.
// Each axis mapping is a multiply, a divider load, 45 divide steps and the add.
// Each iteration is three multiplier passes and an update.
// The colour is one more multiply and divide, then one cycle of result.
// Busy stays high while an item is in flight, through its result strobe;
// the next item can be taken in the cycle after that strobe.
// Reset returns the sequencer to idle and loads the default window.
// The result strobe cannot be stalled; busy stays high until it is shown.
module mandelbrot_escape_pixel_top
	import mep_pkg::*;
#(
	parameter int MAX_DIMENSION = 4096,
	parameter int FRACTION_BITS = 28
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [PIX_W-1:0]    pixel_col,
	input  logic [PIX_W-1:0]    pixel_row,
	output logic                done,
	output logic [COUNT_W-1:0]  escape_count,
	output logic [COLOUR_W-1:0] pixel_colour,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [COORD_W-1:0]  wr_data
);

	localparam int SPAN_W = COORD_W + 1;
	localparam int PROD_W = 2 * SPAN_W;
	localparam int WIDE_W = PROD_W + 1;
	localparam int DVD_W = PIX_W + SPAN_W;
	localparam int STEP_W = $clog2(DVD_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);
	localparam logic [WIDE_W-1:0] BOUND = WIDE_W'(ESCAPE_RADIUS_SQ) << FRACTION_BITS;

	mep_state_t state_q, state_d;

	// Configuration registers
	logic signed [COORD_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic [COUNT_W-1:0] limit_q;

	// Datapath registers
	logic [PIX_W-1:0] col_q, row_q;
	logic signed [SPAN_W-1:0] span_q;
	logic signed [PROD_W-1:0] p_q, xx_q, yy_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, zx_q, zy_q;
	logic [COUNT_W-1:0] count_q;
	logic [DVD_W-1:0] dvd_q;
	logic [COUNT_W-1:0] rem_q, dvs_q;
	logic sign_q;

	// Control flags
	logic sel_y_q, colour_q;
	logic [STEP_W-1:0] step_q;

	logic signed [SPAN_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod, p_mag;
	logic [DIM_W-1:0] dim_sel, dim_clamp;
	logic [COUNT_W:0] rem_sh;
	logic rem_ge;
	logic signed [DVD_W:0] offset;
	logic signed [COORD_W-1:0] lo_sel, map_val, nx, ny;
	logic signed [WIDE_W-1:0] map_sum, nx_sum, ny_sum;
	logic [WIDE_W-1:0] mag_sum;
	logic escaped, at_limit;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-COORD_W:0] top;
		top = v[WIDE_W-1:COORD_W-1];
		if (top == '0 || top == '1)
			return v[COORD_W-1:0];
		else if (v[WIDE_W-1])
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MAP_MUL: begin
				mul_a = {{(SPAN_W-PIX_W){1'b0}}, (sel_y_q ? row_q : col_q)};
				mul_b = span_q;
			end
			ST_IT_XX: begin
				mul_a = {zx_q[COORD_W-1], zx_q};
				mul_b = {zx_q[COORD_W-1], zx_q};
			end
			ST_IT_YY: begin
				mul_a = {zy_q[COORD_W-1], zy_q};
				mul_b = {zy_q[COORD_W-1], zy_q};
			end
			ST_IT_XY: begin
				mul_a = {zx_q[COORD_W-1], zx_q};
				mul_b = {zy_q[COORD_W-1], zy_q};
			end
			ST_CL_MUL: begin
				mul_a = {{(SPAN_W-COUNT_W){1'b0}}, count_q};
				mul_b = {{(SPAN_W-COLOUR_W){1'b0}}, COLOUR_SCALE};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign p_mag = p_q[PROD_W-1] ? -p_q : p_q;

	// Divisor for the axis, clamped to the largest dimension
	assign dim_sel = sel_y_q ? height_q : width_q;
	assign dim_clamp = ({{(32-DIM_W){1'b0}}, dim_sel} > 32'(MAX_DIMENSION))
		? DIM_W'(MAX_DIMENSION) : dim_sel;

	// Restoring divider step
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dvs_q};

	// Axis mapping: min plus signed truncated quotient, saturated
	assign offset = (dvs_q == '0) ? '0
		: (sign_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q}));
	assign lo_sel = sel_y_q ? y_min_q : x_min_q;
	assign map_sum = {{(WIDE_W-COORD_W){lo_sel[COORD_W-1]}}, lo_sel}
		+ {{(WIDE_W-DVD_W-1){offset[DVD_W]}}, offset};
	assign map_val = sat32(map_sum);

	// Iteration update and escape test
	assign mag_sum = {1'b0, xx_q} + {1'b0, yy_q};
	assign escaped = mag_sum > BOUND;
	assign at_limit = count_q >= limit_q;
	assign nx_sum = {xx_q[PROD_W-1], xx_q} - {yy_q[PROD_W-1], yy_q}
		+ {{(WIDE_W-COORD_W){cx_q[COORD_W-1]}}, cx_q};
	assign ny_sum = {p_q[PROD_W-1], (p_q >>> (FRACTION_BITS - 1))}
		+ {{(WIDE_W-COORD_W){cy_q[COORD_W-1]}}, cy_q};
	assign nx = sat32(nx_sum);
	assign ny = sat32(ny_sum);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (start) state_d = ST_MAP_MUL;
			ST_MAP_MUL: state_d = ST_DIV_LD;
			ST_DIV_LD:  state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_LAST)
					state_d = colour_q ? ST_DONE : ST_MAP_ADD;
			end
			ST_MAP_ADD: state_d = sel_y_q ? ST_IT_XX : ST_MAP_MUL;
			ST_IT_XX:   state_d = at_limit ? ST_CL_MUL : ST_IT_YY;
			ST_IT_YY:   state_d = ST_IT_XY;
			ST_IT_XY:   state_d = ST_IT_UPD;
			ST_IT_UPD:  state_d = escaped ? ST_CL_MUL : ST_IT_XX;
			ST_CL_MUL:  state_d = ST_DIV_LD;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= -32'sd536870912;
			x_max_q <= 32'sd536870912;
			y_min_q <= -32'sd536870912;
			y_max_q <= 32'sd536870912;
			width_q <= 13'd1000;
			height_q <= 13'd1000;
			limit_q <= 16'd1000;
		end else if (wr_en) begin
			case (wr_index)
				REG_X_MIN:  x_min_q <= wr_data;
				REG_X_MAX:  x_max_q <= wr_data;
				REG_Y_MIN:  y_min_q <= wr_data;
				REG_Y_MAX:  y_max_q <= wr_data;
				REG_WIDTH:  width_q <= wr_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= wr_data[DIM_W-1:0];
				REG_LIMIT:  limit_q <= wr_data[COUNT_W-1:0];
				default:    ;
			endcase
		end
	end

	// Control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_y_q <= 1'b0;
			colour_q <= 1'b0;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					sel_y_q <= 1'b0;
					colour_q <= 1'b0;
				end
				ST_DIV_LD:  step_q <= '0;
				ST_DIV:     step_q <= step_q + 1'b1;
				ST_MAP_ADD: sel_y_q <= 1'b1;
				ST_CL_MUL:  colour_q <= 1'b1;
				default:    ;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q <= pixel_col;
				row_q <= pixel_row;
				span_q <= {x_max_q[COORD_W-1], x_max_q} - {x_min_q[COORD_W-1], x_min_q};
			end
			ST_MAP_MUL, ST_IT_XX, ST_CL_MUL: p_q <= prod;
			ST_DIV_LD: begin
				sign_q <= p_q[PROD_W-1];
				dvd_q <= p_mag[DVD_W-1:0];
				rem_q <= '0;
				dvs_q <= colour_q ? limit_q : {{(COUNT_W-DIM_W){1'b0}}, dim_clamp};
			end
			ST_DIV: begin
				rem_q <= rem_ge ? COUNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[COUNT_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], rem_ge};
			end
			ST_MAP_ADD: begin
				if (!sel_y_q) begin
					cx_q <= map_val;
					zx_q <= map_val;
					span_q <= {y_max_q[COORD_W-1], y_max_q} - {y_min_q[COORD_W-1], y_min_q};
				end else begin
					zy_q <= map_val;
					count_q <= '0;
				end
			end
			ST_IT_YY: begin
				xx_q <= p_q >>> FRACTION_BITS;
				p_q <= prod;
			end
			ST_IT_XY: begin
				yy_q <= p_q >>> FRACTION_BITS;
				p_q <= prod;
			end
			ST_IT_UPD: begin
				if (!escaped) begin
					zx_q <= nx;
					zy_q <= ny;
					count_q <= count_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Imaginary part of the point, held for the whole iteration
	always_ff @(posedge clk) begin
		if (state_q == ST_MAP_ADD && sel_y_q)
			cy_q <= map_val;
	end

	// Outputs
	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign escape_count = count_q;
	assign pixel_colour = (dvs_q == '0) ? '0 : dvd_q[COLOUR_W-1:0];

endmodule

// ===== hw/rtl/mep_checker.sv =====
module mep_checker
	import mep_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [COLOUR_W-1:0] pixel_colour
);

	// A result only comes while an item is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	// An accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item accepted but block not busy");

	// The block goes idle right after its result
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block still busy after result");

	// Busy only drops after a result was shown
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done)) else $error("item dropped without result");

	// The colour shown with a result never exceeds the full scale
	a_colour_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pixel_colour <= COLOUR_SCALE)) else $error("colour out of range");

endmodule

bind mandelbrot_escape_pixel_top mep_checker u_mep_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.pixel_colour (pixel_colour)
);

// ===== dv/mandelbrot_escape_pixel_top_tb.sv =====
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_top_tb
	import mep_pkg::*;
();

	localparam int MAX_DIM = 4096;
	localparam int FRAC_BITS = 28;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -64'sd2147483648;
	localparam longint ESC_BOUND = longint'(ESCAPE_RADIUS_SQ) << FRAC_BITS;
	localparam int RANDOM_ITEMS = 580;

	typedef enum logic [1:0] {
		STEP_WRITE,
		STEP_PIXEL,
		STEP_PIXEL_KNOWN
	} step_kind_t;

	typedef struct packed {
		step_kind_t           kind;
		logic [2:0]           reg_idx;
		logic [COORD_W-1:0]   data;
		logic [PIX_W-1:0]     col;
		logic [PIX_W-1:0]     row;
		logic [COUNT_W-1:0]   count;
		logic [COLOUR_W-1:0]  colour;
	} plan_step_t;

	typedef struct packed {
		logic [PIX_W-1:0]     col;
		logic [PIX_W-1:0]     row;
		logic [COUNT_W-1:0]   count;
		logic [COLOUR_W-1:0]  colour;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [PIX_W-1:0] pixel_col = '0;
	logic [PIX_W-1:0] pixel_row = '0;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [COORD_W-1:0] wr_data = '0;
	logic busy;
	logic done;
	logic [COUNT_W-1:0] escape_count;
	logic [COLOUR_W-1:0] pixel_colour;

	// Shadow copy of the configuration, power-on values
	int win_x_lo = -536870912;
	int win_x_hi = 536870912;
	int win_y_lo = -536870912;
	int win_y_hi = 536870912;
	logic [DIM_W-1:0] cols_cfg = 13'd1000;
	logic [DIM_W-1:0] rows_cfg = 13'd1000;
	logic [COUNT_W-1:0] limit_cfg = 16'd1000;

	pixel_result_t pending_pixels[$];
	int mismatches = 0;
	int results_seen = 0;
	int pixels_sent = 0;
	int gap_max = 12;
	bit unsettled = 1'b0;

	mandelbrot_escape_pixel_top #(
		.MAX_DIMENSION(MAX_DIM),
		.FRACTION_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.done(done),
		.escape_count(escape_count),
		.pixel_colour(pixel_colour),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #4 clk = ~clk;

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH @%0t: %s", $realtime, what);
	endtask

	// Predictor
	function automatic longint clamp32(input longint v);
		if (v > I32_MAX)
			return I32_MAX;
		if (v < I32_MIN)
			return I32_MIN;
		return v;
	endfunction

	// lo + trunc(idx * (hi - lo) / dim), dim capped, zero dim gives lo
	function automatic longint axis_point(input int lo, input int hi,
			input logic [PIX_W-1:0] idx, input logic [DIM_W-1:0] dim);
		longint span, offs, d, i;
		span = longint'(hi) - longint'(lo);
		d = dim;
		if (d > MAX_DIM)
			d = MAX_DIM;
		i = idx;
		offs = 0;
		if (d != 0)
			offs = (i * span) / d;
		return clamp32(longint'(lo) + offs);
	endfunction

	function automatic int unsigned escape_steps(input longint cx, input longint cy,
			input int unsigned lim);
		longint zx, zy, xx, yy, xy2;
		int unsigned n;
		bit alive;
		zx = cx;
		zy = cy;
		n = 0;
		alive = 1'b1;
		while (alive && n < lim) begin
			xx = (zx * zx) >>> FRAC_BITS;
			yy = (zy * zy) >>> FRAC_BITS;
			if (xx + yy > ESC_BOUND) begin
				alive = 1'b0;
			end else begin
				xy2 = (zx * zy) >>> (FRAC_BITS - 1);
				zx = clamp32(xx - yy + cx);
				zy = clamp32(xy2 + cy);
				n++;
			end
		end
		return n;
	endfunction

	function automatic pixel_result_t predict_pixel(input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] row);
		pixel_result_t r;
		longint cx, cy;
		longint unsigned prod;
		int unsigned n;
		cx = axis_point(win_x_lo, win_x_hi, col, cols_cfg);
		cy = axis_point(win_y_lo, win_y_hi, row, rows_cfg);
		n = escape_steps(cx, cy, limit_cfg);
		prod = COLOUR_SCALE;
		prod = prod * n;
		r.col = col;
		r.row = row;
		r.count = n[COUNT_W-1:0];
		r.colour = (limit_cfg == 0) ? '0 : COLOUR_W'(prod / limit_cfg);
		return r;
	endfunction

	// Driving
	task automatic write_reg(input logic [2:0] idx, input logic [COORD_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			REG_X_MIN: win_x_lo = data;
			REG_X_MAX: win_x_hi = data;
			REG_Y_MIN: win_y_lo = data;
			REG_Y_MAX: win_y_hi = data;
			REG_WIDTH: cols_cfg = data[DIM_W-1:0];
			REG_HEIGHT: rows_cfg = data[DIM_W-1:0];
			REG_LIMIT: limit_cfg = data[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	// Hold start until the block takes the item, then queue its outcome
	task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
			input bit typed, input logic [COUNT_W-1:0] t_count,
			input logic [COLOUR_W-1:0] t_colour);
		pixel_result_t want;
		start <= 1'b1;
		wr_en <= 1'b0;
		pixel_col <= col;
		pixel_row <= row;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (typed) begin
			want.col = col;
			want.row = row;
			want.count = t_count;
			want.colour = t_colour;
		end else begin
			want = predict_pixel(col, row);
		end
		pending_pixels.push_back(want);
		pixels_sent++;
		unsettled = 1'b1;
	endtask

	task automatic sender_gap();
		int unsigned g;
		g = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
		if (g != 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every queued pixel has come back
	task automatic wait_drained(input int tail);
		start <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0 || busy)
			@(posedge clk);
		repeat (tail) @(posedge clk);
		unsettled = 1'b0;
	endtask

	function automatic plan_step_t cfg_step(input logic [2:0] idx,
			input logic [COORD_W-1:0] data);
		plan_step_t s;
		s = '0;
		s.kind = STEP_WRITE;
		s.reg_idx = idx;
		s.data = data;
		return s;
	endfunction

	function automatic plan_step_t pixel_step(input int col, input int row);
		plan_step_t s;
		s = '0;
		s.kind = STEP_PIXEL;
		s.col = PIX_W'(col);
		s.row = PIX_W'(row);
		return s;
	endfunction

	function automatic plan_step_t known_step(input int col, input int row,
			input int count, input int colour);
		plan_step_t s;
		s = pixel_step(col, row);
		s.kind = STEP_PIXEL_KNOWN;
		s.count = COUNT_W'(count);
		s.colour = COLOUR_W'(colour);
		return s;
	endfunction

	// New window, sizes and limit for one random stretch
	task automatic new_phase_setting(output int items);
		int xa, xb, ya, yb, tmp;
		logic [COORD_W-1:0] w, h, lim;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			// window near the set, sometimes flipped
			xa = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
			xb = xa + $urandom_range(32'h0000_1000, 32'h3000_0000);
			ya = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
			yb = ya + $urandom_range(32'h0000_1000, 32'h3000_0000);
			if ($urandom_range(0, 3) == 0) begin
				tmp = xa; xa = xb; xb = tmp;
				tmp = ya; ya = yb; yb = tmp;
			end
		end else if (pick < 8) begin
			xa = $urandom();
			xb = $urandom();
			ya = $urandom();
			yb = $urandom();
		end else begin
			xa = -536870912;
			xb = 536870912;
			ya = -536870912;
			yb = 536870912;
		end
		w = $urandom();
		h = $urandom();
		lim = $urandom();
		case ($urandom_range(0, 9))
			0: w[DIM_W-1:0] = '0;
			1: w[DIM_W-1:0] = DIM_W'(MAX_DIM);
			2: w[DIM_W-1:0] = DIM_W'($urandom_range(MAX_DIM + 1, 8191));
			default: w[DIM_W-1:0] = DIM_W'($urandom_range(1, MAX_DIM));
		endcase
		case ($urandom_range(0, 9))
			0: h[DIM_W-1:0] = '0;
			1: h[DIM_W-1:0] = DIM_W'(MAX_DIM);
			2: h[DIM_W-1:0] = DIM_W'($urandom_range(MAX_DIM + 1, 8191));
			default: h[DIM_W-1:0] = DIM_W'($urandom_range(1, MAX_DIM));
		endcase
		// mostly short limits; long ones get short stretches
		case ($urandom_range(0, 9))
			0: lim[COUNT_W-1:0] = '0;
			1: lim[COUNT_W-1:0] = 16'd1000;
			2, 3: lim[COUNT_W-1:0] = COUNT_W'($urandom_range(49, 300));
			default: lim[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 48));
		endcase
		items = (lim[COUNT_W-1:0] >= 16'd1000) ? 12 : 55;
		write_reg(REG_X_MIN, xa);
		write_reg(REG_X_MAX, xb);
		write_reg(REG_Y_MIN, ya);
		write_reg(REG_Y_MAX, yb);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_LIMIT, lim);
	endtask

	// Result checking
	always @(posedge clk) begin : result_check
		pixel_result_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				flag_mismatch($sformatf("result with nothing pending: count=%0d colour=%06h",
					escape_count, pixel_colour));
			end else begin
				want = pending_pixels.pop_front();
				results_seen++;
				if (escape_count !== want.count)
					flag_mismatch($sformatf("pixel (%0d,%0d) escape_count %0d, want %0d",
						want.col, want.row, escape_count, want.count));
				if (pixel_colour !== want.colour)
					flag_mismatch($sformatf("pixel (%0d,%0d) pixel_colour %06h, want %06h",
						want.col, want.row, pixel_colour, want.colour));
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		plan_step_t plan[$];
		int phase_len, random_sent, phases, directed_sent, eff_cols, eff_rows;
		logic [PIX_W-1:0] col, row;

		// default window: origin never escapes, corner escapes at once
		plan.push_back(known_step(500, 500, 1000, COLOUR_SCALE));
		plan.push_back(known_step(0, 0, 0, 0));
		plan.push_back(pixel_step(4095, 4095));
		plan.push_back(pixel_step(250, 700));
		// zero limit: nothing iterates
		plan.push_back(cfg_step(REG_LIMIT, 0));
		plan.push_back(known_step(500, 500, 0, 0));
		plan.push_back(known_step(4095, 0, 0, 0));
		plan.push_back(cfg_step(REG_LIMIT, 1));
		plan.push_back(known_step(500, 500, 1, COLOUR_SCALE));
		plan.push_back(pixel_step(0, 999));
		// largest limit, point pinned at 2.0 + 0i: one step then out
		plan.push_back(cfg_step(REG_LIMIT, 32'h0000_FFFF));
		plan.push_back(cfg_step(REG_X_MIN, 32'h2000_0000));
		plan.push_back(cfg_step(REG_X_MAX, 32'h2000_0000));
		plan.push_back(cfg_step(REG_Y_MIN, 32'h0000_0000));
		plan.push_back(cfg_step(REG_Y_MAX, 32'h0000_0000));
		plan.push_back(known_step(123, 456, 1, 255));
		plan.push_back(known_step(4095, 4095, 1, 255));
		// coordinate extremes, all far outside
		plan.push_back(cfg_step(REG_X_MIN, 32'h7FFF_FFFF));
		plan.push_back(cfg_step(REG_X_MAX, 32'h7FFF_FFFF));
		plan.push_back(known_step(0, 0, 0, 0));
		plan.push_back(cfg_step(REG_X_MIN, 32'h8000_0000));
		plan.push_back(cfg_step(REG_Y_MIN, 32'h8000_0000));
		plan.push_back(cfg_step(REG_Y_MAX, 32'h8000_0000));
		plan.push_back(known_step(0, 4095, 0, 0));
		plan.push_back(pixel_step(4095, 2048));
		plan.push_back(pixel_step(2048, 0));
		// zero width and height: every pixel lands on the min corner
		plan.push_back(cfg_step(REG_LIMIT, 50));
		plan.push_back(cfg_step(REG_X_MIN, 32'hF000_0000));
		plan.push_back(cfg_step(REG_Y_MIN, 32'h0000_0000));
		plan.push_back(cfg_step(REG_WIDTH, 0));
		plan.push_back(cfg_step(REG_HEIGHT, 0));
		plan.push_back(pixel_step(7, 9));
		plan.push_back(pixel_step(4095, 4095));
		// oversize dimensions clamp; inverted window
		plan.push_back(cfg_step(REG_WIDTH, 32'h0000_1FFF));
		plan.push_back(cfg_step(REG_HEIGHT, 32'h0000_1001));
		plan.push_back(cfg_step(REG_X_MIN, 32'h2000_0000));
		plan.push_back(cfg_step(REG_X_MAX, 32'hE000_0000));
		plan.push_back(cfg_step(REG_Y_MIN, 32'h1000_0000));
		plan.push_back(cfg_step(REG_Y_MAX, 32'hF000_0000));
		plan.push_back(pixel_step(0, 0));
		plan.push_back(pixel_step(2048, 2048));
		plan.push_back(pixel_step(4095, 1));
		plan.push_back(pixel_step(1, 4095));
		// one-pixel image, anything past it is extrapolated
		plan.push_back(cfg_step(REG_WIDTH, 1));
		plan.push_back(cfg_step(REG_HEIGHT, 1));
		plan.push_back(pixel_step(0, 0));
		plan.push_back(pixel_step(1, 1));
		// write to an unused index must change nothing
		plan.push_back(cfg_step(REG_UNUSED, 32'hDEAD_BEEF));
		plan.push_back(pixel_step(4095, 4095));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE) begin
				if (unsettled)
					wait_drained(8);
				write_reg(plan[i].reg_idx, plan[i].data);
			end else begin
				send_pixel(plan[i].col, plan[i].row, plan[i].kind == STEP_PIXEL_KNOWN,
					plan[i].count, plan[i].colour);
				sender_gap();
			end
		end
		directed_sent = pixels_sent;

		// random stretches, each under its own setting
		random_sent = 0;
		phases = 0;
		while (random_sent < RANDOM_ITEMS) begin
			wait_drained(8);
			new_phase_setting(phase_len);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			eff_cols = (cols_cfg == 0) ? 1 : ((cols_cfg > MAX_DIM) ? MAX_DIM : cols_cfg);
			eff_rows = (rows_cfg == 0) ? 1 : ((rows_cfg > MAX_DIM) ? MAX_DIM : rows_cfg);
			repeat (phase_len) begin
				// mostly inside the image, the rest anywhere
				col = ($urandom_range(0, 3) != 0) ? PIX_W'($urandom_range(0, eff_cols - 1))
					: PIX_W'($urandom_range(0, 4095));
				row = ($urandom_range(0, 3) != 0) ? PIX_W'($urandom_range(0, eff_rows - 1))
					: PIX_W'($urandom_range(0, 4095));
				send_pixel(col, row, 1'b0, '0, '0);
				random_sent++;
				sender_gap();
				if ($urandom_range(0, 49) == 0)
					wait_drained(0);
			end
			phases++;
		end

		wait_drained(200);
		$display("Sent %0d pixels (%0d directed) across %0d random window settings.",
			pixels_sent, directed_sent, phases);
		$display("Compared %0d results; %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#(100_000_000);
		$display("Timeout with %0d results still pending.", pending_pixels.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mep_pkg.sv
hw/rtl/mandelbrot_escape_pixel_top.sv
hw/rtl/mep_checker.sv
dv/mandelbrot_escape_pixel_top_tb.sv
